>>> design/running_mean_plus_stddev_macros.svh
// ----------------------------------------------------------------------------
// running_mean_plus_stddev_macros
// Assertion macros for the running mean plus standard deviation block.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEAN_PLUS_STDDEV_MACROS_SVH
`define RUNNING_MEAN_PLUS_STDDEV_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define RMSD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define RMSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rmsd_pkg.sv
// ----------------------------------------------------------------------------
// rmsd_pkg
// Shared types and constants of the running mean plus standard deviation block.
// ----------------------------------------------------------------------------
package rmsd_pkg;

    // fixed field and state widths
    localparam int SAMPLE_W   = 32;
    localparam int MEAN_EXTRA = 16;
    localparam int MEAN_W     = 48;
    localparam int SUM_W      = 64;
    localparam int ROOT_W     = 32;

    // iterations of the shared divide / square-root unit
    localparam int DIV_MEAN_STEPS = MEAN_W;
    localparam int DIV_VAR_STEPS  = SUM_W;
    localparam int ROOT_STEPS     = SUM_W / 2;
    localparam int STEP_CNT_W     = $clog2(SUM_W + 1);

    // register map, word index
    localparam logic REG_INITIAL_MEAN = 1'b0;

    // datapath commands
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_PREP_MEAN,
        OP_DIV_STEP,
        OP_MEAN_UPDATE,
        OP_DEV2,
        OP_MULTIPLY,
        OP_SUM_UPDATE,
        OP_PREP_VAR,
        OP_ROOT_INIT,
        OP_ROOT_STEP,
        OP_OUT_LOAD
    } rmsd_op_t;

endpackage

>>> design/running_mean_plus_stddev.sv
// ----------------------------------------------------------------------------
// running_mean_plus_stddev
// Online mean plus standard deviation estimator for duration samples.
// ----------------------------------------------------------------------------
// Takes one unsigned Q16.16 sample per word and runs a Welford update of a
// Q16.32 mean, a Q32.32 sum of squared deviations and a saturating count that
// starts at one. Each word gives back the rounded mean plus the standard
// deviation, sqrt(sum / (count - 1)), in Q16.16, and the new count. A set
// restart flag first reloads the mean from initial_mean, clears the sum and
// sets the count to one. Each word is taken through the load, mean setup, mean
// quotient, mean update, deviation, multiply, sum update, variance setup,
// variance quotient, root setup, square root and output load steps in that
// order. The quotients and the root come from the shared bit-serial unit,
// which produces one bit per cycle. A new sample is accepted only once the
// previous result has been loaded into the output register. The result sits
// in an output register, so a stall on the output only holds the next item
// once its own result is ready. initial_mean sits at byte address 0 of the
// register port.

`include "running_mean_plus_stddev_macros.svh"

module running_mean_plus_stddev #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // sample words
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] sample,
    input  logic        restart,

    // result words
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] estimate,
    output logic [31:0] sample_count
);

    logic [31:0]         initial_mean_reg;
    logic                reg_write;
    logic                reg_hit;
    logic                out_load;
    rmsd_pkg::rmsd_op_t  op;

    // register port, word index in paddr[2], zero wait states
    assign pready    = 1'b1;
    assign reg_hit   = (paddr[2] == rmsd_pkg::REG_INITIAL_MEAN);
    assign reg_write = psel && penable && pwrite && pready && reg_hit;
    assign prdata    = reg_hit ? initial_mean_reg : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            initial_mean_reg <= '0;
        else if (reg_write)
            initial_mean_reg <= pwdata;
    end

    // sequencer: handshakes and per-cycle command to the datapath
    rmsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .op        (op)
    );

    // welford state, multiplier and shared divide / root unit
    rmsd_dpath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .sample       (sample),
        .restart      (restart),
        .initial_mean (initial_mean_reg),
        .estimate     (estimate),
        .sample_count (sample_count)
    );

    // output register load command from the sequencer
    assign out_load = (op == rmsd_pkg::OP_OUT_LOAD);

    // an accepted word keeps the input side busy on the next cycle
    `RMSD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accept while busy")
    // a result only appears through the output load command
    `RMSD_ASSERT_SAME(a_out_from_load, $rose(out_valid), $past(out_load), "result without load")
    // the count after an update is never below two
    `RMSD_ASSERT_SAME(a_count_nonzero, out_valid, sample_count > 32'd1, "count below two")

endmodule

>>> design/rmsd_ctrl.sv
// ----------------------------------------------------------------------------
// rmsd_ctrl
// Sequencer: steps the datapath through one update and owns the handshakes.
// ----------------------------------------------------------------------------
module rmsd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output rmsd_pkg::rmsd_op_t op
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP_MEAN,
        S_DIV_MEAN,
        S_MEAN_UPD,
        S_DEV2,
        S_MULT,
        S_SUM,
        S_PREP_VAR,
        S_DIV_VAR,
        S_ROOT_INIT,
        S_ROOT,
        S_OUT
    } state_t;

    localparam int CW = rmsd_pkg::STEP_CNT_W;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        op             = rmsd_pkg::OP_IDLE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = rmsd_pkg::OP_LOAD;
                    state_next = S_PREP_MEAN;
                end
            end
            S_PREP_MEAN:
            begin
                op         = rmsd_pkg::OP_PREP_MEAN;
                cnt_next   = CW'(rmsd_pkg::DIV_MEAN_STEPS - 1);
                state_next = S_DIV_MEAN;
            end
            S_DIV_MEAN:
            begin
                op = rmsd_pkg::OP_DIV_STEP;
                if (cnt_reg == '0)
                    state_next = S_MEAN_UPD;
                else
                    cnt_next = cnt_reg - CW'(1);
            end
            S_MEAN_UPD:
            begin
                op         = rmsd_pkg::OP_MEAN_UPDATE;
                state_next = S_DEV2;
            end
            S_DEV2:
            begin
                op         = rmsd_pkg::OP_DEV2;
                state_next = S_MULT;
            end
            S_MULT:
            begin
                op         = rmsd_pkg::OP_MULTIPLY;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                op         = rmsd_pkg::OP_SUM_UPDATE;
                state_next = S_PREP_VAR;
            end
            S_PREP_VAR:
            begin
                op         = rmsd_pkg::OP_PREP_VAR;
                cnt_next   = CW'(rmsd_pkg::DIV_VAR_STEPS - 1);
                state_next = S_DIV_VAR;
            end
            S_DIV_VAR:
            begin
                op = rmsd_pkg::OP_DIV_STEP;
                if (cnt_reg == '0)
                    state_next = S_ROOT_INIT;
                else
                    cnt_next = cnt_reg - CW'(1);
            end
            S_ROOT_INIT:
            begin
                op         = rmsd_pkg::OP_ROOT_INIT;
                cnt_next   = CW'(rmsd_pkg::ROOT_STEPS - 1);
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                op = rmsd_pkg::OP_ROOT_STEP;
                if (cnt_reg == '0)
                    state_next = S_OUT;
                else
                    cnt_next = cnt_reg - CW'(1);
            end
            S_OUT:
            begin
                // wait here while the previous word is still held
                if (!out_valid_reg || !out_stall)
                begin
                    op             = rmsd_pkg::OP_OUT_LOAD;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> design/rmsd_dpath.sv
// ----------------------------------------------------------------------------
// rmsd_dpath
// Welford state, deviation rounding, multiplier and the shared bit-serial
// divide / square-root unit.
// ----------------------------------------------------------------------------
module rmsd_dpath #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rmsd_pkg::rmsd_op_t        op,
    input  logic [31:0]               sample,
    input  logic                      restart,
    input  logic [31:0]               initial_mean,
    output logic [31:0]               estimate,
    output logic [31:0]               sample_count
);

    localparam int MW  = rmsd_pkg::MEAN_W;
    localparam int SW  = rmsd_pkg::SUM_W;
    localparam int RTW = rmsd_pkg::ROOT_W;
    localparam int EX  = rmsd_pkg::MEAN_EXTRA;
    localparam int RW  = (COUNT_WIDTH > 34) ? COUNT_WIDTH : 34;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

    // architectural state
    logic [31:0]            sample_reg;
    logic [MW-1:0]          mean_reg;
    logic [SW-1:0]          sum_reg;
    logic [COUNT_WIDTH-1:0] count_reg;

    // working registers
    logic [SW-1:0]          acc_reg;
    logic [RW-1:0]          rem_reg;
    logic [RTW-1:0]         root_reg;
    logic [COUNT_WIDTH-1:0] div_reg;
    logic [31:0]            d1_reg, d2_reg;
    logic                   neg1_reg, neg2_reg;
    logic [SW-1:0]          prod_reg;
    logic [31:0]            estimate_reg, sample_count_reg;

    // combinational
    logic [COUNT_WIDTH-1:0] count_base, count_inc;
    logic [MW-1:0]          sx;
    logic [MW:0]            delta, delta_negated;
    logic                   delta_neg;
    logic [MW-1:0]          delta_mag;
    logic [31:0]            dev_rounded;
    logic [RW:0]            div_trial, div_ext, div_diff;
    logic                   div_ge;
    logic [RW+1:0]          root_trial, root_ext, root_diff;
    logic                   root_ge;
    logic [SW-1:0]          prod_full;
    logic                   sum_sub;
    logic [SW:0]            sum_add;
    logic [SW-1:0]          sum_new;
    logic [MW:0]            mean_round;
    logic [33:0]            est_sum;
    logic [63:0]            count_ext;

    function automatic logic [31:0] round_dev(input logic [MW-1:0] m);
        logic [MW:0] r;
        logic [MW-EX:0] q;
        r = {1'b0, m} + ((MW+1)'(1) << (EX - 1));
        q = r[MW:EX];
        round_dev = (q[MW-EX:32] != '0) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    // count bookkeeping at accept, restart first
    assign count_base = restart ? COUNT_ONE : count_reg;
    assign count_inc  = (count_base == COUNT_MAX) ? count_base : count_base + COUNT_ONE;

    // deviation of the sample from the current mean
    assign sx            = {sample_reg, {EX{1'b0}}};
    assign delta         = {1'b0, sx} - {1'b0, mean_reg};
    assign delta_neg     = delta[MW];
    assign delta_negated = ~delta + (MW+1)'(1);
    assign delta_mag     = delta_neg ? delta_negated[MW-1:0] : delta[MW-1:0];
    assign dev_rounded   = round_dev(delta_mag);

    // restoring divide step, one quotient bit per cycle
    assign div_trial = {rem_reg, acc_reg[SW-1]};
    assign div_ext   = (RW+1)'(div_reg);
    assign div_ge    = (div_trial >= div_ext);
    assign div_diff  = div_trial - div_ext;

    // square-root step, one root bit per cycle
    assign root_trial = {rem_reg, acc_reg[SW-1:SW-2]};
    assign root_ext   = (RW+2)'({root_reg, 2'b01});
    assign root_ge    = (root_trial >= root_ext);
    assign root_diff  = root_trial - root_ext;

    assign prod_full = 64'(d1_reg) * 64'(d2_reg);

    // saturating sum update, a negative product only comes from rounding
    assign sum_sub = (neg1_reg != neg2_reg) && (prod_reg != '0);
    assign sum_add = {1'b0, sum_reg} + {1'b0, prod_reg};
    always_comb
    begin
        if (sum_sub)
            sum_new = (sum_reg > prod_reg) ? sum_reg - prod_reg : '0;
        else
            sum_new = sum_add[SW] ? '1 : sum_add[SW-1:0];
    end

    // mean rounded half up plus the root
    assign mean_round = {1'b0, mean_reg} + ((MW+1)'(1) << (EX - 1));
    assign est_sum    = 34'(mean_round[MW:EX]) + 34'(root_reg);
    assign count_ext  = 64'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg  <= '0;
            sum_reg   <= '0;
            count_reg <= COUNT_ONE;
        end
        else
        begin
            unique case (op)
                rmsd_pkg::OP_LOAD:
                begin
                    count_reg <= count_inc;
                    if (restart)
                    begin
                        mean_reg <= {initial_mean, {EX{1'b0}}};
                        sum_reg  <= '0;
                    end
                end
                rmsd_pkg::OP_MEAN_UPDATE:
                begin
                    mean_reg <= neg1_reg ? mean_reg - acc_reg[MW-1:0]
                                         : mean_reg + acc_reg[MW-1:0];
                end
                rmsd_pkg::OP_SUM_UPDATE:
                begin
                    sum_reg <= sum_new;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (op)
            rmsd_pkg::OP_LOAD:
            begin
                sample_reg <= sample;
            end
            rmsd_pkg::OP_PREP_MEAN:
            begin
                acc_reg  <= {delta_mag, {(SW-MW){1'b0}}};
                rem_reg  <= '0;
                div_reg  <= count_reg;
                d1_reg   <= dev_rounded;
                neg1_reg <= delta_neg;
            end
            rmsd_pkg::OP_DIV_STEP:
            begin
                rem_reg <= div_ge ? div_diff[RW-1:0] : div_trial[RW-1:0];
                acc_reg <= {acc_reg[SW-2:0], div_ge};
            end
            rmsd_pkg::OP_DEV2:
            begin
                d2_reg   <= dev_rounded;
                neg2_reg <= delta_neg;
            end
            rmsd_pkg::OP_MULTIPLY:
            begin
                prod_reg <= prod_full;
            end
            rmsd_pkg::OP_PREP_VAR:
            begin
                acc_reg <= sum_reg;
                rem_reg <= '0;
                div_reg <= (count_reg > COUNT_ONE) ? count_reg - COUNT_ONE : COUNT_ONE;
            end
            rmsd_pkg::OP_ROOT_INIT:
            begin
                rem_reg  <= '0;
                root_reg <= '0;
            end
            rmsd_pkg::OP_ROOT_STEP:
            begin
                rem_reg  <= root_ge ? root_diff[RW-1:0] : root_trial[RW-1:0];
                root_reg <= {root_reg[RTW-2:0], root_ge};
                acc_reg  <= {acc_reg[SW-3:0], 2'b00};
            end
            rmsd_pkg::OP_OUT_LOAD:
            begin
                estimate_reg     <= (est_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF
                                                              : est_sum[31:0];
                sample_count_reg <= (count_ext > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                         : count_ext[31:0];
            end
            default:
            begin
            end
        endcase
    end

    assign estimate     = estimate_reg;
    assign sample_count = sample_count_reg;

endmodule
